[rtl/core/svpt_pkg.sv]
// ----------------------------------------------------------------------------
// svpt_pkg
// Shared types and constants for the space vector PWM timing block.
// ----------------------------------------------------------------------------
package svpt_pkg;

  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
  } vec_t;

  typedef struct packed {
    logic [14:0] compare_u;
    logic [14:0] compare_v;
    logic [14:0] compare_w;
    logic [2:0]  sector;
    logic        overmodulated;
  } result_t;

  typedef struct packed {
    logic empty;
    logic almost_full;
  } fifo_stat_t;

  localparam int unsigned CFG_W = 16;

  localparam logic REG_BUS_VOLTAGE = 1'b0;
  localparam logic REG_PWM_PERIOD  = 1'b1;

  localparam logic [14:0] BUS_VOLTAGE_RST = 15'd6144;
  localparam logic [15:0] PWM_PERIOD_RST  = 16'd17000;

  localparam logic [2:0] SEC1 = 3'd1;
  localparam logic [2:0] SEC2 = 3'd2;
  localparam logic [2:0] SEC3 = 3'd3;
  localparam logic [2:0] SEC4 = 3'd4;
  localparam logic [2:0] SEC5 = 3'd5;
  localparam logic [2:0] SEC6 = 3'd6;

  // sqrt(3) scaled by 1e9, used to derive the fixed-point constant.
  localparam logic [63:0] SQRT3_NANO = 64'd1732050808;
  localparam logic [63:0] NANO       = 64'd1000000000;

  // Overmodulated sums at or above 2^NORM_LIMIT_BITS are halved before the rescale.
  localparam int unsigned NORM_LIMIT_BITS = 39;
  localparam int unsigned TOTAL_W         = NORM_LIMIT_BITS + 1;

endpackage

[rtl/core/space_vector_pwm_timing.sv]
// ----------------------------------------------------------------------------
// space_vector_pwm_timing
// Seven-segment space vector PWM: sector, active times and phase compares.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer condition        Payload
// vec       in         start && !busy            vec_t (v_alpha, v_beta)
// result    out        done (one cycle, no stall) result_t
// config    in         cfg_we                    cfg_index, cfg_data
//
// A new vector may be taken every cycle; results leave in order, one per
// vector. Most of the delay lies in the two bit-serial divider pipelines
// (one bit per stage) and the halving stages.
// Reset clears all control state and restores both registers to their
// defaults. The result side cannot stall; busy rises only if the queue
// between front and back is almost full.
// ----------------------------------------------------------------------------
module space_vector_pwm_timing #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  svpt_pkg::vec_t               vec,
  output logic                         done,
  output svpt_pkg::result_t            result,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [svpt_pkg::CFG_W-1:0]   cfg_data
);

  localparam int unsigned M  = FRACTION_BITS + 19;
  localparam int unsigned IW = 3 + 2 * M;

  logic [14:0] bus_voltage;
  logic [15:0] pwm_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_voltage <= svpt_pkg::BUS_VOLTAGE_RST;
      pwm_period  <= svpt_pkg::PWM_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == svpt_pkg::REG_BUS_VOLTAGE) begin
        bus_voltage <= cfg_data[14:0];
      end
      if (cfg_index == svpt_pkg::REG_PWM_PERIOD) begin
        pwm_period <= cfg_data;
      end
    end
  end

  svpt_pkg::fifo_stat_t fstat;
  logic                 push;
  logic [2:0]           push_sector;
  logic [M-1:0]         push_nx;
  logic [M-1:0]         push_ny;
  logic [IW-1:0]        head;

  assign busy = fstat.almost_full;

  svpt_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (start && !busy),
    .vec         (vec),
    .push        (push),
    .push_sector (push_sector),
    .push_nx     (push_nx),
    .push_ny     (push_ny)
  );

  svpt_fifo #(.W(IW), .DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sector, push_nx, push_ny}),
    .pop       (!fstat.empty),
    .head      (head),
    .stat      (fstat)
  );

  svpt_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!fstat.empty),
    .in_data     (head),
    .bus_voltage (bus_voltage),
    .pwm_period  (pwm_period),
    .done        (done),
    .result      (result)
  );

endmodule

[rtl/core/svpt_div2.sv]
// ----------------------------------------------------------------------------
// svpt_div2
// Pipelined restoring divider, two dividends over one shared divisor.
// ----------------------------------------------------------------------------
module svpt_div2 #(
  parameter int unsigned DW = 50,
  parameter int unsigned VW = 16,
  parameter int unsigned QB = 49,
  parameter int unsigned SW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] num_a,
  input  logic [DW-1:0] num_b,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quo_a,
  output logic [QB-1:0] quo_b,
  output logic [SW-1:0] side_out
);

  // The upper field holds the partial remainder; the lower field feeds the
  // next dividend bit out of its top and takes the quotient bit at its bottom.
  function automatic logic [VW+QB-1:0] step(input logic [VW+QB-1:0] x,
                                            input logic [VW-1:0] d);
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;
    trial = x[VW+QB-1:QB-1];
    diff  = trial - {1'b0, d};
    ge    = trial >= {1'b0, d};
    return {(ge ? diff[VW-1:0] : trial[VW-1:0]), x[QB-2:0], ge};
  endfunction

  logic [VW+QB-1:0] init_a;
  logic [VW+QB-1:0] init_b;
  logic [VW+QB-1:0] ra [QB];
  logic [VW+QB-1:0] rb [QB];
  logic [VW-1:0]    dv [QB];
  logic [SW-1:0]    sd [QB];
  logic [QB-1:0]    vld;

  assign init_a = {VW'(num_a >> QB), num_a[QB-1:0]};
  assign init_b = {VW'(num_b >> QB), num_b[QB-1:0]};

  for (genvar s = 0; s < QB; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else begin
          vld[s] <= in_valid;
        end
        ra[s] <= step(init_a, divisor);
        rb[s] <= step(init_b, divisor);
        dv[s] <= divisor;
        sd[s] <= side_in;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else begin
          vld[s] <= vld[s-1];
        end
        ra[s] <= step(ra[s-1], dv[s-1]);
        rb[s] <= step(rb[s-1], dv[s-1]);
        dv[s] <= dv[s-1];
        sd[s] <= sd[s-1];
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign quo_a     = ra[QB-1][QB-1:0];
  assign quo_b     = rb[QB-1][QB-1:0];
  assign side_out  = sd[QB-1];

endmodule

[rtl/core/svpt_fifo.sv]
// ----------------------------------------------------------------------------
// svpt_fifo
// Short flip-flop queue between the front and the back of the block.
// ----------------------------------------------------------------------------
module svpt_fifo #(
  parameter int unsigned W     = 73,
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [W-1:0]         push_data,
  input  logic                 pop,
  output logic [W-1:0]         head,
  output svpt_pkg::fifo_stat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(do_pop);
    end
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  assign head = mem[rptr];

  // Two front stages may be in flight, so the front is held off early.
  assign stat.empty       = (count == '0);
  assign stat.almost_full = (count >= (AW+1)'(DEPTH - 2));

endmodule

[rtl/core/svpt_front.sv]
// ----------------------------------------------------------------------------
// svpt_front
// Sign tests, sector decode and selection of the two active time numerators.
// ----------------------------------------------------------------------------
module svpt_front #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  svpt_pkg::vec_t      vec,
  output logic                push,
  output logic [2:0]          push_sector,
  output logic [FRACTION_BITS+18:0] push_nx,
  output logic [FRACTION_BITS+18:0] push_ny
);

  localparam int unsigned SBW = FRACTION_BITS + 19;
  localparam int unsigned SSW = FRACTION_BITS + 20;
  localparam int unsigned M   = FRACTION_BITS + 19;
  localparam logic [63:0] KFULL =
    ((svpt_pkg::SQRT3_NANO << FRACTION_BITS) + (svpt_pkg::NANO >> 1)) / svpt_pkg::NANO;
  localparam logic [FRACTION_BITS+1:0] K = KFULL[FRACTION_BITS+1:0];

  function automatic logic [M-1:0] mag(input logic signed [SSW-1:0] x);
    return x[SSW-1] ? M'(-x) : M'(x);
  endfunction

  logic                  s1_vld;
  logic signed [SBW-1:0] s1_sb;
  logic signed [SBW-1:0] s1_a3;
  logic                  s1_bpos;
  logic signed [SBW-1:0] a_ext;
  logic signed [SSW-1:0] x2;
  logic signed [SSW-1:0] y2;
  logic signed [SSW-1:0] z2;
  logic [2:0]            raw;
  logic [2:0]            sec;
  logic [M-1:0]          mx;
  logic [M-1:0]          my;
  logic [M-1:0]          mz;
  logic [M-1:0]          nx;
  logic [M-1:0]          ny;

  assign a_ext = SBW'($signed(vec.v_alpha));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= take;
    end
    s1_sb   <= SBW'($signed(vec.v_beta) * $signed({1'b0, K}));
    s1_a3   <= (a_ext + (a_ext <<< 1)) <<< FRACTION_BITS;
    s1_bpos <= $signed(vec.v_beta) > 0;
  end

  assign x2 = SSW'(s1_sb) <<< 1;
  assign y2 = SSW'(s1_a3) + SSW'(s1_sb);
  assign z2 = SSW'(s1_sb) - SSW'(s1_a3);
  assign mx = mag(x2);
  assign my = mag(y2);
  assign mz = mag(z2);

  // A zero vector gives no sector from the sign tests and is run as sector VI.
  assign raw = {y2[SSW-1], z2[SSW-1], s1_bpos};
  assign sec = (raw == 3'd0 || raw == 3'd7) ? svpt_pkg::SEC6 : raw;

  always_comb begin
    unique case (sec)
      svpt_pkg::SEC1: begin nx = mz; ny = my; end
      svpt_pkg::SEC2: begin nx = my; ny = mx; end
      svpt_pkg::SEC3: begin nx = mz; ny = mx; end
      svpt_pkg::SEC4: begin nx = mx; ny = mz; end
      svpt_pkg::SEC5: begin nx = mx; ny = my; end
      default:        begin nx = my; ny = mz; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= s1_vld;
    end
    push_sector <= sec;
    push_nx     <= nx;
    push_ny     <= ny;
  end

endmodule

[rtl/core/svpt_back.sv]
// ----------------------------------------------------------------------------
// svpt_back
// Active times, overmodulation rescale and compare value assignment.
// ----------------------------------------------------------------------------
module svpt_back #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [3+2*(FRACTION_BITS+19)-1:0] in_data,
  input  logic [14:0]                  bus_voltage,
  input  logic [15:0]                  pwm_period,
  output logic                         done,
  output svpt_pkg::result_t            result
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned M   = F + 19;
  localparam int unsigned PW  = M + 16;
  localparam int unsigned TW  = PW - 1;
  localparam int unsigned NSH = PW - svpt_pkg::NORM_LIMIT_BITS;
  localparam int unsigned PQW = F + 16;
  localparam int unsigned LB  = svpt_pkg::NORM_LIMIT_BITS;
  localparam int unsigned QW  = LB + 16;
  localparam int unsigned DW2 = QW + F;
  localparam int unsigned SW2 = 4 + 2 * PQW;

  logic [2:0]     in_sec;
  logic [M-1:0]   in_nx;
  logic [M-1:0]   in_ny;
  logic [14:0]    bv_eff;
  logic [PQW-1:0] pq;

  assign {in_sec, in_nx, in_ny} = in_data;
  assign bv_eff = (bus_voltage == '0) ? 15'd1 : bus_voltage;
  assign pq     = {pwm_period, F'(0)};

  // Numerators times the period.
  logic          a_vld;
  logic [2:0]    a_sec;
  logic [PW-1:0] a_px;
  logic [PW-1:0] a_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
    end
    a_sec <= in_sec;
    a_px  <= PW'(in_nx) * PW'(pwm_period);
    a_py  <= PW'(in_ny) * PW'(pwm_period);
  end

  logic          d1_vld;
  logic [TW-1:0] d1_tx;
  logic [TW-1:0] d1_ty;
  logic [2:0]    d1_sec;

  svpt_div2 #(.DW(PW), .VW(16), .QB(TW), .SW(3)) u_div_time (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_vld),
    .num_a     (a_px),
    .num_b     (a_py),
    .divisor   ({bv_eff, 1'b0}),
    .side_in   (a_sec),
    .out_valid (d1_vld),
    .quo_a     (d1_tx),
    .quo_b     (d1_ty),
    .side_out  (d1_sec)
  );

  // Overmodulation test, then one halving per stage while the sum is too wide.
  logic [TW-1:0] n_tx   [NSH+1];
  logic [TW-1:0] n_ty   [NSH+1];
  logic [2:0]    n_sec  [NSH+1];
  logic          n_over [NSH+1];
  logic [NSH:0]  n_vld;
  logic [TW:0]   d1_sum;

  assign d1_sum = (TW+1)'(d1_tx) + (TW+1)'(d1_ty);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld[0] <= 1'b0;
    end else begin
      n_vld[0] <= d1_vld;
    end
    n_tx[0]   <= d1_tx;
    n_ty[0]   <= d1_ty;
    n_sec[0]  <= d1_sec;
    n_over[0] <= d1_sum > (TW+1)'(pq);
  end

  for (genvar s = 1; s <= NSH; s++) begin : g_norm
    logic [TW:0] sum;
    logic        wide;
    assign sum  = (TW+1)'(n_tx[s-1]) + (TW+1)'(n_ty[s-1]);
    assign wide = n_over[s-1] && ((sum >> LB) != '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        n_vld[s] <= 1'b0;
      end else begin
        n_vld[s] <= n_vld[s-1];
      end
      n_tx[s]   <= wide ? (n_tx[s-1] >> 1) : n_tx[s-1];
      n_ty[s]   <= wide ? (n_ty[s-1] >> 1) : n_ty[s-1];
      n_sec[s]  <= n_sec[s-1];
      n_over[s] <= n_over[s-1];
    end
  end

  // Rescale operands.
  logic                    r_vld;
  logic [QW-1:0]           r_qx;
  logic [QW-1:0]           r_qy;
  logic [svpt_pkg::TOTAL_W-1:0] r_tot;
  logic [SW2-1:0]          r_side;
  logic [TW:0]             n_sum;

  assign n_sum = (TW+1)'(n_tx[NSH]) + (TW+1)'(n_ty[NSH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= n_vld[NSH];
    end
    r_qx   <= QW'(n_tx[NSH][LB-1:0]) * QW'(pwm_period);
    r_qy   <= QW'(n_ty[NSH][LB-1:0]) * QW'(pwm_period);
    r_tot  <= n_sum[svpt_pkg::TOTAL_W-1:0];
    r_side <= {n_sec[NSH], n_over[NSH], n_tx[NSH][PQW-1:0], n_ty[NSH][PQW-1:0]};
  end

  logic           d2_vld;
  logic [PQW-1:0] d2_qx;
  logic [PQW-1:0] d2_qy;
  logic [SW2-1:0] d2_side;

  svpt_div2 #(.DW(DW2), .VW(svpt_pkg::TOTAL_W), .QB(PQW), .SW(SW2)) u_div_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_vld),
    .num_a     ({r_qx, F'(0)}),
    .num_b     ({r_qy, F'(0)}),
    .divisor   (r_tot),
    .side_in   (r_side),
    .out_valid (d2_vld),
    .quo_a     (d2_qx),
    .quo_b     (d2_qy),
    .side_out  (d2_side)
  );

  logic [2:0]     d2_sec;
  logic           d2_over;
  logic [PQW-1:0] d2_px;
  logic [PQW-1:0] d2_py;
  logic [PQW-1:0] fx;
  logic [PQW-1:0] fy;

  assign {d2_sec, d2_over, d2_px, d2_py} = d2_side;
  assign fx = d2_over ? d2_qx : d2_px;
  assign fy = d2_over ? d2_qy : d2_py;

  // The scaled times never sum past the period, so the zero segment is
  // non-negative.
  logic           f_vld;
  logic [PQW-1:0] f_tx;
  logic [PQW-1:0] f_ty;
  logic [PQW-1:0] f_ta;
  logic [2:0]     f_sec;
  logic           f_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= d2_vld;
    end
    f_tx   <= fx;
    f_ty   <= fy;
    f_ta   <= (pq - fx - fy) >> 2;
    f_sec  <= d2_sec;
    f_over <= d2_over;
  end

  logic [PQW-1:0] tb;
  logic [PQW-1:0] tc;
  logic [PQW-1:0] cu;
  logic [PQW-1:0] cv;
  logic [PQW-1:0] cw;

  assign tb = (f_tx >> 1) + f_ta;
  assign tc = (f_ty >> 1) + tb;

  always_comb begin
    unique case (f_sec)
      svpt_pkg::SEC1: begin cu = tb;   cv = f_ta; cw = tc;   end
      svpt_pkg::SEC2: begin cu = f_ta; cv = tc;   cw = tb;   end
      svpt_pkg::SEC3: begin cu = f_ta; cv = tb;   cw = tc;   end
      svpt_pkg::SEC4: begin cu = tc;   cv = tb;   cw = f_ta; end
      svpt_pkg::SEC5: begin cu = tc;   cv = f_ta; cw = tb;   end
      default:        begin cu = tb;   cv = tc;   cw = f_ta; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_vld;
    end
    result.compare_u     <= cu[F+14:F];
    result.compare_v     <= cv[F+14:F];
    result.compare_w     <= cw[F+14:F];
    result.sector        <= f_sec;
    result.overmodulated <= f_over;
  end

endmodule

[sim/tb_space_vector_pwm_timing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_space_vector_pwm_timing
// Drives voltage vectors under several bus voltage and period settings and
// checks every compare triple, sector and overmodulation flag against a
// fixed-point prediction kept in the testbench.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_timing;

  localparam int unsigned FB = 16;
  localparam int unsigned LATENCY = 3 * FB + 54;

  class svpwm_scoreboard;
    svpt_pkg::result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    logic [14:0] bus_v;
    logic [15:0] period;

    function new();
      errors = 0;
      checked = 0;
      bus_v = svpt_pkg::BUS_VOLTAGE_RST;
      period = svpt_pkg::PWM_PERIOD_RST;
    endfunction

    function logic [63:0] dwell(logic [63:0] m);
      logic [63:0] d;
      d = 2 * ((bus_v == 0) ? 64'd1 : 64'(bus_v));
      return (m * 64'(period)) / d;
    endfunction

    function logic [63:0] fit(logic [63:0] t, logic [63:0] sum);
      logic [63:0] q;
      q = t * 64'(period);
      return ((q / sum) << FB) + (((q % sum) << FB) / sum);
    endfunction

    function logic [63:0] absval(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function void note_vector(svpt_pkg::vec_t v);
      longint a, b, root3, sb, a3, x2, y2, z2;
      logic [2:0] sec;
      logic [63:0] tmx, tmy, tmz, tx, ty, sum, pq, ta, tb, tc, cu, cv, cw;
      logic over;
      svpt_pkg::result_t r;
      root3 = longint'(((64'd1732050808 << FB) + 64'd500000000) / 64'd1000000000);
      a = longint'(v.v_alpha);
      b = longint'(v.v_beta);
      sb = root3 * b;
      a3 = 3 * a * (longint'(1) << FB);
      x2 = 2 * sb;
      y2 = a3 + sb;
      z2 = sb - a3;
      sec = {y2 < 0, z2 < 0, b > 0};
      if (sec == 3'd0 || sec == 3'd7) sec = svpt_pkg::SEC6;
      tmx = dwell(absval(x2));
      tmy = dwell(absval(y2));
      tmz = dwell(absval(z2));
      case (sec)
        svpt_pkg::SEC1: begin tx = tmz; ty = tmy; end
        svpt_pkg::SEC2: begin tx = tmy; ty = tmx; end
        svpt_pkg::SEC3: begin tx = tmz; ty = tmx; end
        svpt_pkg::SEC4: begin tx = tmx; ty = tmz; end
        svpt_pkg::SEC5: begin tx = tmx; ty = tmy; end
        default: begin tx = tmy; ty = tmz; end
      endcase
      pq = 64'(period) << FB;
      sum = tx + ty;
      over = 1'b0;
      if (sum > pq) begin
        over = 1'b1;
        while ((sum >> svpt_pkg::NORM_LIMIT_BITS) != 0) begin
          tx = tx >> 1;
          ty = ty >> 1;
          sum = tx + ty;
        end
        tx = fit(tx, sum);
        ty = fit(ty, sum);
      end
      ta = (pq - (tx + ty)) >> 2;
      tb = (tx >> 1) + ta;
      tc = (ty >> 1) + tb;
      case (sec)
        svpt_pkg::SEC1: begin cu = tb; cv = ta; cw = tc; end
        svpt_pkg::SEC2: begin cu = ta; cv = tc; cw = tb; end
        svpt_pkg::SEC3: begin cu = ta; cv = tb; cw = tc; end
        svpt_pkg::SEC4: begin cu = tc; cv = tb; cw = ta; end
        svpt_pkg::SEC5: begin cu = tc; cv = ta; cw = tb; end
        default: begin cu = tb; cv = tc; cw = ta; end
      endcase
      r.compare_u = cu[FB +: 15];
      r.compare_v = cv[FB +: 15];
      r.compare_w = cw[FB +: 15];
      r.sector = sec;
      r.overmodulated = over;
      pending.push_back(r);
    endfunction

    function void check_result(svpt_pkg::result_t got);
      svpt_pkg::result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: %p", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.compare_u !== want.compare_u)
        $display("%0t: compare_u expected %0d got %0d", $time, want.compare_u, got.compare_u);
      if (got.compare_v !== want.compare_v)
        $display("%0t: compare_v expected %0d got %0d", $time, want.compare_v, got.compare_v);
      if (got.compare_w !== want.compare_w)
        $display("%0t: compare_w expected %0d got %0d", $time, want.compare_w, got.compare_w);
      if (got.sector !== want.sector)
        $display("%0t: sector expected %0d got %0d", $time, want.sector, got.sector);
      if (got.overmodulated !== want.overmodulated)
        $display("%0t: overmodulated expected %0b got %0b", $time, want.overmodulated,
                 got.overmodulated);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  svpt_pkg::vec_t vec = '0;
  logic done;
  svpt_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = svpt_pkg::REG_BUS_VOLTAGE;
  logic [svpt_pkg::CFG_W-1:0] cfg_data = '0;

  svpwm_scoreboard sb = new();
  bit quiet;
  int unsigned sent;

  space_vector_pwm_timing #(.FRACTION_BITS(FB)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .vec(vec),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Offers one vector and holds it until the transfer; a random gap may precede it.
  // Start stays high after the transfer so that vectors can follow back to back.
  task automatic send_vector(logic [15:0] a, logic [15:0] b);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    vec <= '{v_alpha: a, v_beta: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_vector(vec);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == svpt_pkg::REG_BUS_VOLTAGE) sb.bus_v = val[14:0];
    else sb.period = val;
    @(negedge clk);
  endtask

  // Most vectors are of moderate size so that both normal and overmodulated cases occur.
  task automatic random_vectors(int unsigned n);
    logic [15:0] a, b;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin a = $urandom(); b = $urandom(); end
        1: begin a = 16'($signed($urandom_range(0, 1023)) - 512);
                 b = 16'($signed($urandom_range(0, 1023)) - 512); end
        2: begin a = 16'($signed($urandom_range(0, 16383)) - 8192);
                 b = 16'($signed($urandom_range(0, 16383)) - 8192); end
        default: begin a = 16'($signed($urandom_range(0, 15)) - 8);
                       b = 16'($signed($urandom_range(0, 15)) - 8); end
      endcase
      send_vector(a, b);
    end
  endtask

  initial begin
    quiet = 1'b0;
    sent = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero vector, axis extremes, one vector per sector, boundary signs.
    send_vector(16'h0000, 16'h0000);
    send_vector(16'h7FFF, 16'h0000);
    send_vector(16'h8000, 16'h0000);
    send_vector(16'h0000, 16'h7FFF);
    send_vector(16'h0000, 16'h8000);
    send_vector(16'h7FFF, 16'h7FFF);
    send_vector(16'h8000, 16'h8000);
    send_vector(16'h7FFF, 16'h8000);
    send_vector(16'h8000, 16'h7FFF);
    send_vector(16'h0100, 16'h0040);
    send_vector(16'h0020, 16'h0100);
    send_vector(16'hFF00, 16'h0040);
    send_vector(16'hFF00, 16'hFFC0);
    send_vector(16'h0020, 16'hFF00);
    send_vector(16'h0100, 16'hFFC0);
    send_vector(16'hFFFF, 16'h0000);
    send_vector(16'h0001, 16'h0001);
    send_vector(16'hFFFF, 16'hFFFF);
    drain();

    // Register extremes, including values outside the nominal range.
    write_reg(svpt_pkg::REG_BUS_VOLTAGE, 16'h0000);
    write_reg(svpt_pkg::REG_PWM_PERIOD, 16'd0);
    send_vector(16'h0000, 16'h0000);
    send_vector(16'h0100, 16'h0100);
    random_vectors(40);
    drain();
    write_reg(svpt_pkg::REG_PWM_PERIOD, 16'd1);
    random_vectors(40);
    drain();
    write_reg(svpt_pkg::REG_BUS_VOLTAGE, 16'h7FFF);
    write_reg(svpt_pkg::REG_PWM_PERIOD, 16'hFFFF);
    random_vectors(300);
    drain();
    write_reg(svpt_pkg::REG_BUS_VOLTAGE, 16'd1);
    write_reg(svpt_pkg::REG_PWM_PERIOD, 16'd2);
    random_vectors(200);
    drain();
    write_reg(svpt_pkg::REG_BUS_VOLTAGE, 16'd1);
    write_reg(svpt_pkg::REG_PWM_PERIOD, 16'hFFFF);
    random_vectors(200);
    drain();
    repeat (4) begin
      write_reg(svpt_pkg::REG_BUS_VOLTAGE, 16'($urandom_range(1, 32767)));
      write_reg(svpt_pkg::REG_PWM_PERIOD, 16'($urandom_range(2, 65535)));
      random_vectors(150);
      drain();
    end
    write_reg(svpt_pkg::REG_BUS_VOLTAGE, 16'(svpt_pkg::BUS_VOLTAGE_RST));
    write_reg(svpt_pkg::REG_PWM_PERIOD, svpt_pkg::PWM_PERIOD_RST);
    quiet = 1'b1;
    random_vectors(300);
    drain();

    $display("Sent %0d vectors across ten register settings; %0d results checked.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("space_vector_pwm_timing: match");
    end else begin
      $display("space_vector_pwm_timing: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("space_vector_pwm_timing: mismatch");
    $finish;
  end
endmodule
